// ----- rtl/core/cfa_pkg.sv -----
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types, codes and constants of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int MAX_HOLES_DEF  = 16;
    localparam int MAX_ALLOCS_DEF = 16;

    localparam int ADDR_W = 20;
    localparam int SIZE_W = 21;
    localparam int PID_W  = 8;

    localparam logic [SIZE_W-1:0] REGION_LIMIT = 21'd1048576;

    // item kinds
    localparam logic [1:0] KIND_REQUEST = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_COMPACT = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    // fit modes
    localparam logic [1:0] MODE_FIRST   = 2'd0;
    localparam logic [1:0] MODE_BEST    = 2'd1;
    localparam logic [1:0] MODE_WORST   = 2'd2;
    localparam logic [1:0] MODE_INVALID = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_HOLE  = 3'd1;
    localparam logic [2:0] ST_BAD_MODE = 3'd2;
    localparam logic [2:0] ST_NO_PROC  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [1:0]        kind;
        logic [PID_W-1:0]  process_id;
        logic [SIZE_W-1:0] request_size;
        logic [1:0]        fit_mode;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] start_address;
        logic [SIZE_W-1:0] allocated_total;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } t_hole;

    typedef struct packed {
        logic [PID_W-1:0]  owner;
        logic [ADDR_W-1:0] start;
        logic [SIZE_W-1:0] size;
    } t_alloc;

    // per-cycle command broadcast along a row of table cells
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_DELETE
    } t_cell_op;

endpackage

// ----- rtl/core/cfa_cell.sv -----
// ----------------------------------------------------------------------------
// cfa_cell
// One table entry of a cell row: holds, loads, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module cfa_cell #(
    parameter int W     = 41,
    parameter int IDX_W = 4,
    parameter int IDX   = 0
) (
    input  logic              i_clk,
    input  cfa_pkg::t_cell_op i_op,
    input  logic [IDX_W-1:0]  i_pos,
    input  logic [W-1:0]      i_load,
    input  logic [W-1:0]      i_lower,
    input  logic [W-1:0]      i_upper,
    output logic [W-1:0]      o_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [W-1:0] r_data;

    // load at the broadcast position, shift up on insert, shift down on delete
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            cfa_pkg::CELL_HOLD: begin
            end
            cfa_pkg::CELL_WRITE: begin
                if (i_pos == MY_IDX) r_data <= i_load;
            end
            cfa_pkg::CELL_INSERT: begin
                if (i_pos == MY_IDX) r_data <= i_load;
                else if (MY_IDX > i_pos) r_data <= i_lower;
            end
            cfa_pkg::CELL_DELETE: begin
                if (MY_IDX >= i_pos) r_data <= i_upper;
            end
            default: begin
            end
        endcase
    end

    assign o_data = r_data;

endmodule

// ----- rtl/core/contiguous_fit_allocator.sv -----
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// Contiguous memory allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_item) carries request,
//   release, compact and status items. Output channel (o_out_valid /
//   i_out_ready, o_out_item) returns exactly one result item per input item.
//   Configuration channel (i_cfg_valid / o_cfg_ready, i_cfg_data) sets the
//   region size and resets both tables; it is taken only while idle.
// Flow: one item at a time. A status query goes straight to its result; a
//   request scans the holes and then the allocations; a release scans the
//   allocations and then the holes, with an extra step when it merges on both
//   sides; a compact walks the allocations. Each table is read one entry
//   per cycle through a single read port.
// Reset: synchronous active low; after reset the init state loads the single
//   hole spanning the whole region, then the block takes items.
// Stall: a finished result waits in the output register; the block moves on
//   to the next item and holds its next result until the output is taken.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator #(
    parameter int MAX_HOLES  = cfa_pkg::MAX_HOLES_DEF,
    parameter int MAX_ALLOCS = cfa_pkg::MAX_ALLOCS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  cfa_pkg::t_in_item         i_in_item,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output cfa_pkg::t_out_item        o_out_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [cfa_pkg::SIZE_W-1:0] i_cfg_data
);

    localparam int AW  = cfa_pkg::ADDR_W;
    localparam int SW  = cfa_pkg::SIZE_W;
    localparam int HW  = $bits(cfa_pkg::t_hole);
    localparam int LW  = $bits(cfa_pkg::t_alloc);
    localparam int HIW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int AIW = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
    localparam int HCW = $clog2(MAX_HOLES + 1);
    localparam int ACW = $clog2(MAX_ALLOCS + 1);
    localparam int IW  = (HCW > ACW) ? HCW : ACW;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_HSCAN, S_CARVE, S_AFIND, S_ASCAN, S_HFIND,
        S_RCHK, S_RAPPLY, S_RDROP, S_COMPACT, S_CHOLE, S_DONE
    } t_state;

    t_state              r_state;
    logic [HCW-1:0]      r_hc;
    logic [ACW-1:0]      r_ac;
    logic [SW-1:0]       r_bytes;
    logic [SW-1:0]       r_total;
    logic [IW-1:0]       r_idx;
    cfa_pkg::t_in_item   r_item;
    logic                r_found;
    logic [HIW-1:0]      r_pick;
    logic [AW-1:0]       r_pick_start;
    logic [SW-1:0]       r_pick_size;
    logic [AW-1:0]       r_s;
    logic [SW-1:0]       r_z;
    logic [IW-1:0]       r_k;
    logic [IW-1:0]       r_p;
    logic                r_jp;
    logic                r_jn;
    logic [AW-1:0]       r_prev_start;
    logic [SW-1:0]       r_prev_size;
    logic [SW-1:0]       r_next_size;
    logic [SW-1:0]       r_cursor;
    logic [2:0]          r_status;
    logic [AW-1:0]       r_addr;
    logic                r_out_valid;
    cfa_pkg::t_out_item  r_out;

    logic [HW-1:0]       w_hole [MAX_HOLES];
    logic [LW-1:0]       w_alloc [MAX_ALLOCS];
    cfa_pkg::t_cell_op   w_hop;
    cfa_pkg::t_cell_op   w_aop;
    logic [HIW-1:0]      w_hpos;
    logic [AIW-1:0]      w_apos;
    cfa_pkg::t_hole      w_hload;
    cfa_pkg::t_alloc     w_aload;
    cfa_pkg::t_hole      w_hrd;
    cfa_pkg::t_alloc     w_ard;
    logic                w_hend;
    logic                w_aend;
    logic                w_fits;
    logic [SW-1:0]       w_cfg_size;
    logic                w_out_free;

    // ---------------------------------------------------------------- cell rows
    for (genvar gi = 0; gi < MAX_HOLES; gi++) begin : g_hole
        logic [HW-1:0] w_lo;
        logic [HW-1:0] w_up;
        if (gi == 0) begin : g_lo0
            assign w_lo = '0;
        end else begin : g_lo
            assign w_lo = w_hole[gi-1];
        end
        if (gi == MAX_HOLES - 1) begin : g_upn
            assign w_up = '0;
        end else begin : g_up
            assign w_up = w_hole[gi+1];
        end
        cfa_cell #(.W(HW), .IDX_W(HIW), .IDX(gi)) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_hop),
            .i_pos   (w_hpos),
            .i_load  (w_hload),
            .i_lower (w_lo),
            .i_upper (w_up),
            .o_data  (w_hole[gi])
        );
    end

    for (genvar gi = 0; gi < MAX_ALLOCS; gi++) begin : g_alloc
        logic [LW-1:0] w_lo;
        logic [LW-1:0] w_up;
        if (gi == 0) begin : g_lo0
            assign w_lo = '0;
        end else begin : g_lo
            assign w_lo = w_alloc[gi-1];
        end
        if (gi == MAX_ALLOCS - 1) begin : g_upn
            assign w_up = '0;
        end else begin : g_up
            assign w_up = w_alloc[gi+1];
        end
        cfa_cell #(.W(LW), .IDX_W(AIW), .IDX(gi)) u_cell (
            .i_clk   (i_clk),
            .i_op    (w_aop),
            .i_pos   (w_apos),
            .i_load  (w_aload),
            .i_lower (w_lo),
            .i_upper (w_up),
            .o_data  (w_alloc[gi])
        );
    end

    // ---------------------------------------------------------------- scan read
    assign w_hrd  = cfa_pkg::t_hole'(w_hole[r_idx[HIW-1:0]]);
    assign w_ard  = cfa_pkg::t_alloc'(w_alloc[r_idx[AIW-1:0]]);
    assign w_hend = (r_idx == IW'(r_hc));
    assign w_aend = (r_idx == IW'(r_ac));
    assign w_fits = (w_hrd.size >= r_item.request_size);

    // clamp the region size
    always_comb begin
        w_cfg_size = i_cfg_data;
        if (i_cfg_data == '0) w_cfg_size = SW'(1);
        else if (i_cfg_data > cfa_pkg::REGION_LIMIT) w_cfg_size = cfa_pkg::REGION_LIMIT;
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // ---------------------------------------------------------------- cell commands
    always_comb begin
        w_hop   = cfa_pkg::CELL_HOLD;
        w_aop   = cfa_pkg::CELL_HOLD;
        w_hpos  = '0;
        w_apos  = '0;
        w_hload = '0;
        w_aload = '0;
        unique case (r_state)
            S_INIT: begin
                w_hop        = cfa_pkg::CELL_WRITE;
                w_hload.size = cfa_pkg::REGION_LIMIT;
            end
            S_IDLE: begin
                if (i_cfg_valid) begin
                    w_hop        = cfa_pkg::CELL_WRITE;
                    w_hload.size = w_cfg_size;
                end
            end
            S_CARVE: begin
                w_hpos = r_pick;
                if (r_pick_size == r_item.request_size) begin
                    w_hop = cfa_pkg::CELL_DELETE;
                end else begin
                    w_hop         = cfa_pkg::CELL_WRITE;
                    w_hload.start = AW'(r_pick_start + r_item.request_size[AW-1:0]);
                    w_hload.size  = r_pick_size - r_item.request_size;
                end
            end
            S_AFIND: begin
                if (w_aend || w_ard.start >= r_pick_start) begin
                    w_aop         = cfa_pkg::CELL_INSERT;
                    w_apos        = r_idx[AIW-1:0];
                    w_aload.owner = r_item.process_id;
                    w_aload.start = r_pick_start;
                    w_aload.size  = r_item.request_size;
                end
            end
            S_RAPPLY: begin
                w_aop  = cfa_pkg::CELL_DELETE;
                w_apos = r_k[AIW-1:0];
                if (r_jp) begin
                    w_hop         = cfa_pkg::CELL_WRITE;
                    w_hpos        = HIW'(r_p - IW'(1));
                    w_hload.start = r_prev_start;
                    w_hload.size  = r_jn ? SW'(r_prev_size + r_z + r_next_size)
                                         : SW'(r_prev_size + r_z);
                end else if (r_jn) begin
                    w_hop         = cfa_pkg::CELL_WRITE;
                    w_hpos        = r_p[HIW-1:0];
                    w_hload.start = r_s;
                    w_hload.size  = SW'(r_next_size + r_z);
                end else begin
                    w_hop         = cfa_pkg::CELL_INSERT;
                    w_hpos        = r_p[HIW-1:0];
                    w_hload.start = r_s;
                    w_hload.size  = r_z;
                end
            end
            S_RDROP: begin
                w_hop  = cfa_pkg::CELL_DELETE;
                w_hpos = r_p[HIW-1:0];
            end
            S_COMPACT: begin
                if (!w_aend) begin
                    w_aop         = cfa_pkg::CELL_WRITE;
                    w_apos        = r_idx[AIW-1:0];
                    w_aload       = w_ard;
                    w_aload.start = r_cursor[AW-1:0];
                end
            end
            S_CHOLE: begin
                if (r_total > r_bytes) begin
                    w_hop         = cfa_pkg::CELL_WRITE;
                    w_hload.start = r_bytes[AW-1:0];
                    w_hload.size  = r_total - r_bytes;
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_hc        <= HCW'(1);
            r_ac        <= '0;
            r_bytes     <= '0;
            r_total     <= cfa_pkg::REGION_LIMIT;
            r_out_valid <= 1'b0;
        end else begin
            // drop the output item once taken, unless a new one loads now
            if (r_out_valid && i_out_ready && r_state != S_DONE) r_out_valid <= 1'b0;

            unique case (r_state)
                S_INIT: begin
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_total <= w_cfg_size;
                        r_hc    <= HCW'(1);
                        r_ac    <= '0;
                        r_bytes <= '0;
                    end else if (i_in_valid) begin
                        r_item   <= i_in_item;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_cursor <= '0;
                        r_status <= cfa_pkg::ST_OK;
                        r_addr   <= '0;
                        priority case (i_in_item.kind)
                            cfa_pkg::KIND_REQUEST: begin
                                if (i_in_item.fit_mode != cfa_pkg::MODE_FIRST &&
                                    i_in_item.fit_mode != cfa_pkg::MODE_BEST &&
                                    i_in_item.fit_mode != cfa_pkg::MODE_WORST) begin
                                    r_status <= cfa_pkg::ST_BAD_MODE;
                                    r_state  <= S_DONE;
                                end else if (r_ac >= ACW'(MAX_ALLOCS)) begin
                                    r_status <= cfa_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else if (i_in_item.request_size == '0) begin
                                    r_status <= cfa_pkg::ST_NO_HOLE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_HSCAN;
                                end
                            end
                            cfa_pkg::KIND_RELEASE: r_state <= S_ASCAN;
                            cfa_pkg::KIND_COMPACT: r_state <= S_COMPACT;
                            default:               r_state <= S_DONE;
                        endcase
                    end
                end
                S_HSCAN: begin
                    if (w_hend) begin
                        if (r_found) begin
                            r_state <= S_CARVE;
                        end else begin
                            r_status <= cfa_pkg::ST_NO_HOLE;
                            r_state  <= S_DONE;
                        end
                    end else begin
                        r_idx <= r_idx + IW'(1);
                        if (w_fits && (!r_found ||
                            (r_item.fit_mode == cfa_pkg::MODE_BEST && w_hrd.size < r_pick_size) ||
                            (r_item.fit_mode == cfa_pkg::MODE_WORST && w_hrd.size > r_pick_size)))
                        begin
                            r_found      <= 1'b1;
                            r_pick       <= r_idx[HIW-1:0];
                            r_pick_start <= w_hrd.start;
                            r_pick_size  <= w_hrd.size;
                            if (r_item.fit_mode == cfa_pkg::MODE_FIRST) r_state <= S_CARVE;
                        end
                    end
                end
                S_CARVE: begin
                    if (r_pick_size == r_item.request_size) r_hc <= r_hc - HCW'(1);
                    r_idx   <= '0;
                    r_state <= S_AFIND;
                end
                S_AFIND: begin
                    if (w_aend || w_ard.start >= r_pick_start) begin
                        r_ac    <= r_ac + ACW'(1);
                        r_bytes <= SW'(r_bytes + r_item.request_size);
                        r_addr  <= r_pick_start;
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_ASCAN: begin
                    if (w_aend) begin
                        r_status <= cfa_pkg::ST_NO_PROC;
                        r_state  <= S_DONE;
                    end else if (w_ard.owner == r_item.process_id) begin
                        r_k     <= r_idx;
                        r_s     <= w_ard.start;
                        r_z     <= w_ard.size;
                        r_idx   <= '0;
                        r_state <= S_HFIND;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_HFIND: begin
                    if (w_hend || w_hrd.start >= r_s) begin
                        r_p         <= r_idx;
                        r_next_size <= w_hrd.size;
                        r_jn        <= !w_hend &&
                                       ({2'b00, r_s} + {1'b0, r_z} == {2'b00, w_hrd.start});
                        r_jp        <= (r_idx != '0) &&
                                       ({2'b00, r_prev_start} + {1'b0, r_prev_size} ==
                                        {2'b00, r_s});
                        r_state     <= S_RCHK;
                    end else begin
                        r_prev_start <= w_hrd.start;
                        r_prev_size  <= w_hrd.size;
                        r_idx        <= r_idx + IW'(1);
                    end
                end
                S_RCHK: begin
                    if (!r_jp && !r_jn && r_hc >= HCW'(MAX_HOLES)) begin
                        r_status <= cfa_pkg::ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_RAPPLY;
                    end
                end
                S_RAPPLY: begin
                    r_ac    <= r_ac - ACW'(1);
                    r_bytes <= r_bytes - r_z;
                    if (!r_jp && !r_jn) r_hc <= r_hc + HCW'(1);
                    r_state <= (r_jp && r_jn) ? S_RDROP : S_DONE;
                end
                S_RDROP: begin
                    r_hc    <= r_hc - HCW'(1);
                    r_state <= S_DONE;
                end
                S_COMPACT: begin
                    if (w_aend) begin
                        r_state <= S_CHOLE;
                    end else begin
                        r_cursor <= SW'(r_cursor + w_ard.size);
                        r_idx    <= r_idx + IW'(1);
                    end
                end
                S_CHOLE: begin
                    r_hc    <= (r_total > r_bytes) ? HCW'(1) : '0;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid           <= 1'b1;
                        r_out.status          <= r_status;
                        r_out.start_address   <= r_addr;
                        r_out.allocated_total <= r_bytes;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // ---------------------------------------------------------------- checks
    a_hole_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hc <= HCW'(MAX_HOLES))
        else $error("hole count beyond table depth");

    a_alloc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ac <= ACW'(MAX_ALLOCS))
        else $error("allocation count beyond table depth");

    a_bytes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes <= r_total)
        else $error("allocated bytes exceed region size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid && $stable(r_out))
        else $error("pending result item overwritten");

endmodule

// ----- tb/contiguous_fit_allocator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_test
// Self-checking bench for the contiguous fit allocator. A directed table
// covers the edge cases, then random request/release/compact/status traffic
// runs over several region sizes. Each result is compared with a local model
// of the hole and allocation tables, or with the value its directed row gives.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator_test;

    localparam int NH        = cfa_pkg::MAX_HOLES_DEF;
    localparam int NA        = cfa_pkg::MAX_ALLOCS_DEF;
    localparam int SETTLE    = 64;
    localparam int IDLE_MAX  = 4000;
    localparam int PHASE_LEN = 400;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    cfa_pkg::t_in_item  i_in_item = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    cfa_pkg::t_out_item o_out_item;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [cfa_pkg::SIZE_W-1:0] i_cfg_data = '0;

    contiguous_fit_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Allocator model: hole table, allocation table, byte count
    // ------------------------------------------------------------------
    int unsigned hole_base[NH];
    int unsigned hole_len[NH];
    int unsigned hole_num;
    int unsigned blk_owner[NA];
    int unsigned blk_base[NA];
    int unsigned blk_len[NA];
    int unsigned blk_num;
    int unsigned bytes_used;
    int unsigned region_size;

    cfa_pkg::t_out_item pending_results[$];
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;

    function automatic void clear_tables();
        hole_base[0] = 0;
        hole_len[0]  = region_size;
        hole_num     = 1;
        blk_num      = 0;
        bytes_used   = 0;
    endfunction

    function automatic void remove_hole(int unsigned idx);
        for (int unsigned j = idx; j + 1 < hole_num; j++) begin
            hole_base[j] = hole_base[j+1];
            hole_len[j]  = hole_len[j+1];
        end
        hole_num--;
    endfunction

    function automatic logic [2:0] model_request(int unsigned pid, int unsigned sz,
                                                 logic [1:0] mode, output int unsigned addr);
        int unsigned pick;
        int unsigned a;
        int unsigned p;
        bit          found;
        pick  = 0;
        found = 0;
        addr  = 0;
        if (mode != cfa_pkg::MODE_FIRST && mode != cfa_pkg::MODE_BEST &&
            mode != cfa_pkg::MODE_WORST)
            return cfa_pkg::ST_BAD_MODE;
        if (blk_num >= NA) return cfa_pkg::ST_FULL;
        if (sz == 0) return cfa_pkg::ST_NO_HOLE;
        for (int unsigned i = 0; i < hole_num; i++) begin
            if (hole_len[i] < sz) continue;
            if (!found) begin
                pick  = i;
                found = 1;
                if (mode == cfa_pkg::MODE_FIRST) break;
            end else if (mode == cfa_pkg::MODE_BEST && hole_len[i] < hole_len[pick]) begin
                pick = i;
            end else if (mode == cfa_pkg::MODE_WORST && hole_len[i] > hole_len[pick]) begin
                pick = i;
            end
        end
        if (!found) return cfa_pkg::ST_NO_HOLE;
        // carve from the low end of the chosen hole
        a = hole_base[pick];
        hole_base[pick] = (a + sz) & 32'hFFFFF;
        hole_len[pick]  = hole_len[pick] - sz;
        if (hole_len[pick] == 0) remove_hole(pick);
        // insert the block in address order
        p = 0;
        while (p < blk_num && blk_base[p] < a) p++;
        for (int unsigned j = blk_num; j > p; j--) begin
            blk_owner[j] = blk_owner[j-1];
            blk_base[j]  = blk_base[j-1];
            blk_len[j]   = blk_len[j-1];
        end
        blk_owner[p] = pid;
        blk_base[p]  = a;
        blk_len[p]   = sz;
        blk_num++;
        bytes_used = (bytes_used + sz) & 32'h1FFFFF;
        addr = a;
        return cfa_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] model_release(int unsigned pid);
        int unsigned k;
        int unsigned s;
        int unsigned z;
        int unsigned p;
        bit          jp;
        bit          jn;
        for (k = 0; k < blk_num; k++)
            if (blk_owner[k] == pid) break;
        if (k >= blk_num) return cfa_pkg::ST_NO_PROC;
        s = blk_base[k];
        z = blk_len[k];
        p = 0;
        while (p < hole_num && hole_base[p] < s) p++;
        jp = p > 0 && hole_base[p-1] + hole_len[p-1] == s;
        jn = p < hole_num && s + z == hole_base[p];
        if (!jp && !jn && hole_num >= NH) return cfa_pkg::ST_FULL;
        for (int unsigned j = k; j + 1 < blk_num; j++) begin
            blk_owner[j] = blk_owner[j+1];
            blk_base[j]  = blk_base[j+1];
            blk_len[j]   = blk_len[j+1];
        end
        blk_num--;
        // merge the freed range with its neighbors
        if (jp && jn) begin
            hole_len[p-1] = hole_len[p-1] + z + hole_len[p];
            remove_hole(p);
        end else if (jp) begin
            hole_len[p-1] = hole_len[p-1] + z;
        end else if (jn) begin
            hole_base[p] = s;
            hole_len[p]  = hole_len[p] + z;
        end else begin
            for (int unsigned j = hole_num; j > p; j--) begin
                hole_base[j] = hole_base[j-1];
                hole_len[j]  = hole_len[j-1];
            end
            hole_base[p] = s;
            hole_len[p]  = z;
            hole_num++;
        end
        bytes_used = (bytes_used - z) & 32'h1FFFFF;
        return cfa_pkg::ST_OK;
    endfunction

    function automatic void model_compact();
        int unsigned cursor;
        cursor = 0;
        for (int unsigned k = 0; k < blk_num; k++) begin
            blk_base[k] = cursor & 32'hFFFFF;
            cursor += blk_len[k];
        end
        if (region_size > bytes_used) begin
            hole_base[0] = bytes_used & 32'hFFFFF;
            hole_len[0]  = region_size - bytes_used;
            hole_num     = 1;
        end else begin
            hole_num = 0;
        end
    endfunction

    function automatic cfa_pkg::t_out_item predict_result(cfa_pkg::t_in_item it);
        cfa_pkg::t_out_item r;
        int unsigned        addr;
        logic [2:0]         st;
        st   = cfa_pkg::ST_OK;
        addr = 0;
        unique case (it.kind)
            cfa_pkg::KIND_REQUEST: st = model_request(32'(it.process_id),
                                                      32'(it.request_size),
                                                      it.fit_mode, addr);
            cfa_pkg::KIND_RELEASE: st = model_release(32'(it.process_id));
            cfa_pkg::KIND_COMPACT: model_compact();
            default: ;
        endcase
        if (st != cfa_pkg::ST_OK) addr = 0;
        r.status          = st;
        r.start_address   = addr[cfa_pkg::ADDR_W-1:0];
        r.allocated_total = bytes_used[cfa_pkg::SIZE_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    int burst_left = 0;

    // present one item and hold it until taken; returns at the next falling edge
    task automatic send_item(cfa_pkg::t_in_item it, bit typed, cfa_pkg::t_out_item want);
        cfa_pkg::t_out_item got;
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        got = predict_result(it);
        pending_results.push_back(typed ? want : got);
        burst_left--;
        @(negedge i_clk);
    endtask

    // drain, let the block settle, then load a new region size
    task automatic write_region(logic [cfa_pkg::SIZE_W-1:0] value);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (value == 0) region_size = 1;
        else if (value > cfa_pkg::REGION_LIMIT) region_size = 32'(cfa_pkg::REGION_LIMIT);
        else region_size = 32'(value);
        clear_tables();
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        cfa_pkg::t_in_item  it;
        bit                 typed;
        cfa_pkg::t_out_item want;
    } t_row;

    t_row directed_rows[$];

    function automatic void add_row(logic [1:0] kind, logic [7:0] pid, logic [20:0] sz,
                                    logic [1:0] mode, bit typed, logic [2:0] st,
                                    logic [19:0] addr, logic [20:0] tot);
        t_row r;
        r.it    = '{kind: kind, process_id: pid, request_size: sz, fit_mode: mode};
        r.typed = typed;
        r.want  = '{status: st, start_address: addr, allocated_total: tot};
        directed_rows.push_back(r);
    endfunction

    function automatic cfa_pkg::t_in_item random_item();
        cfa_pkg::t_in_item it;
        int unsigned       pick;
        int unsigned       cap;
        pick = $urandom_range(0, 99);
        cap  = (region_size / 6 > 1) ? region_size / 6 : 1;
        it.kind = (pick < 45) ? cfa_pkg::KIND_REQUEST :
                  (pick < 80) ? cfa_pkg::KIND_RELEASE :
                  (pick < 90) ? cfa_pkg::KIND_COMPACT : cfa_pkg::KIND_STATUS;
        it.process_id = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 7))
                                                   : 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 4)       it.request_size = '0;
        else if (pick < 9)  it.request_size = 21'($urandom());
        else if (pick < 13) it.request_size = region_size[cfa_pkg::SIZE_W-1:0];
        else                it.request_size = 21'($urandom_range(1, cap));
        it.fit_mode = ($urandom_range(0, 19) == 0) ? cfa_pkg::MODE_INVALID
                                                  : 2'($urandom_range(0, 2));
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Receiver: stall pattern that switches between four modes at random
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;
    int phase_tick = 0;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
        end
        stall_left--;
        phase_tick++;
        unique case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: i_out_ready <= ($urandom_range(0, 7) == 0);
            default: i_out_ready <= (phase_tick % 3 != 0);
        endcase
    end

    // compare each taken result with the oldest expectation
    always @(posedge i_clk) begin
        cfa_pkg::t_out_item want;
        if (o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d addr %0h total %0d",
                             o_out_item.status, o_out_item.start_address,
                             o_out_item.allocated_total);
            end else begin
                want = pending_results.pop_front();
                if (o_out_item.status !== want.status ||
                    o_out_item.start_address !== want.start_address ||
                    o_out_item.allocated_total !== want.allocated_total) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: expected status %0d addr %0h total %0d,",
                                  " got %0d %0h %0d"},
                                 want.status, want.start_address, want.allocated_total,
                                 o_out_item.status, o_out_item.start_address,
                                 o_out_item.allocated_total);
                end
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_MAX) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    logic [cfa_pkg::SIZE_W-1:0] region_plan[5];

    initial begin
        region_size = 32'(cfa_pkg::REGION_LIMIT);
        clear_tables();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // edge cases after reset
        add_row(cfa_pkg::KIND_STATUS,  8'd0,   21'd0,     cfa_pkg::MODE_FIRST,   1,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_REQUEST, 8'd1,   21'd16,    cfa_pkg::MODE_INVALID, 1,
                cfa_pkg::ST_BAD_MODE, 0, 0);
        add_row(cfa_pkg::KIND_REQUEST, 8'd1,   21'd0,     cfa_pkg::MODE_FIRST,   1,
                cfa_pkg::ST_NO_HOLE,  0, 0);
        add_row(cfa_pkg::KIND_RELEASE, 8'd5,   21'd0,     cfa_pkg::MODE_FIRST,   1,
                cfa_pkg::ST_NO_PROC,  0, 0);
        add_row(cfa_pkg::KIND_REQUEST, 8'd0,   cfa_pkg::REGION_LIMIT, cfa_pkg::MODE_FIRST, 1,
                cfa_pkg::ST_OK,       0, cfa_pkg::REGION_LIMIT);
        add_row(cfa_pkg::KIND_REQUEST, 8'd1,   21'd1,     cfa_pkg::MODE_BEST,    1,
                cfa_pkg::ST_NO_HOLE,  0, cfa_pkg::REGION_LIMIT);
        add_row(cfa_pkg::KIND_COMPACT, 8'd9,   21'h1FFFFF, cfa_pkg::MODE_INVALID, 1,
                cfa_pkg::ST_OK,       0, cfa_pkg::REGION_LIMIT);
        add_row(cfa_pkg::KIND_RELEASE, 8'd0,   21'd0,     cfa_pkg::MODE_FIRST,   1,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_REQUEST, 8'd255, 21'd1,     cfa_pkg::MODE_BEST,    1,
                cfa_pkg::ST_OK,       0, 1);
        add_row(cfa_pkg::KIND_REQUEST, 8'd7,   21'd100,   cfa_pkg::MODE_WORST,   0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_REQUEST, 8'd8,   21'h1FFFFF, cfa_pkg::MODE_WORST,  1,
                cfa_pkg::ST_NO_HOLE,  0, 101);
        add_row(cfa_pkg::KIND_REQUEST, 8'd7,   21'd50,    cfa_pkg::MODE_FIRST,   0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_RELEASE, 8'd255, 21'd0,     cfa_pkg::MODE_FIRST,   0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_REQUEST, 8'd3,   21'd1,     cfa_pkg::MODE_BEST,    0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_RELEASE, 8'd7,   21'd0,     cfa_pkg::MODE_FIRST,   0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_REQUEST, 8'd170, 21'd2,     cfa_pkg::MODE_WORST,   0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_COMPACT, 8'd85,  21'h0AAAAA, cfa_pkg::MODE_INVALID, 0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_STATUS,  8'd255, 21'h155555, cfa_pkg::MODE_INVALID, 0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_RELEASE, 8'd7,   21'd0,     cfa_pkg::MODE_FIRST,   0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_RELEASE, 8'd3,   21'd0,     cfa_pkg::MODE_FIRST,   0,
                cfa_pkg::ST_OK,       0, 0);
        add_row(cfa_pkg::KIND_RELEASE, 8'd170, 21'd0,     cfa_pkg::MODE_FIRST,   0,
                cfa_pkg::ST_OK,       0, 0);
        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);

        // random phases over several region sizes, extremes included
        region_plan[0] = 21'h1FFFFF;
        region_plan[1] = 21'd0;
        region_plan[2] = 21'd100;
        region_plan[3] = 21'($urandom_range(16, 4096));
        region_plan[4] = cfa_pkg::REGION_LIMIT;
        foreach (region_plan[ph]) begin
            write_region(region_plan[ph]);
            for (int n = 0; n < PHASE_LEN; n++) begin
                // hold off once per phase until every result is back
                if (n == PHASE_LEN / 2) begin
                    i_in_valid <= 1'b0;
                    burst_left = 0;
                    while (pending_results.size() != 0) @(negedge i_clk);
                end
                send_item(random_item(), 0, '0);
            end
        end

        // drain and let the block go quiet
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
